// ===== design/sbtd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbtd_pkg
// shared constants and types for the six-bit text decoder
// ----------------------------------------------------------------------------
`default_nettype none

package sbtd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CAP_BITS   = 16;
    localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

    localparam logic [7:0]          SYMBOL_OFFSET = 8'h3c;
    localparam logic [CAP_BITS-1:0] CAP_RESET     = {CAP_BITS{1'b1}};

    typedef logic [7:0]            t_char;
    typedef logic [7:0]            t_byte;
    typedef logic [CAP_BITS-1:0]   t_cap;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [15:0]           t_length;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2,
        PH_FOURTH = 2'd3
    } t_phase;

endpackage

`default_nettype wire

// ===== design/six_bit_text_decoder.sv =====
// ----------------------------------------------------------------------------
// six_bit_text_decoder
// decodes an offset six-bit alphabet string into bytes, while not stalled one character a cycle
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                    | payload
//  char     | in        | i_char_valid / o_char_stall  | i_char_in
//  result   | out       | o_res_valid / i_res_stall    | byte_valid, data_byte,
//           |           |                              | done_res, bad_char, length
//  cfg      | in        | i_cfg_valid / o_cfg_ready    | i_cfg_data (out_capacity)
//
//  one transaction per cycle unless the input is stalled; result appears the cycle after acceptance
//  decode state and result register update in the same edge as acceptance
//  input stalls only while a held result is stalled downstream
//  reset clears decode state and sets capacity to all ones
// ----------------------------------------------------------------------------
`default_nettype none

module six_bit_text_decoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_char_valid,
    output logic                  o_char_stall,
    input  wire  sbtd_pkg::t_char i_char_in,
    output logic                  o_res_valid,
    input  wire                   i_res_stall,
    output logic                  o_byte_valid,
    output sbtd_pkg::t_byte       o_data_byte,
    output logic                  o_done_res,
    output logic                  o_bad_char,
    output sbtd_pkg::t_length     o_length,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  sbtd_pkg::t_cap  i_cfg_data
);
    import sbtd_pkg::*;

    t_cap   r_capacity;
    t_byte  r_partial, n_partial;
    t_phase r_phase, n_phase;
    t_count r_count, n_count;
    logic   r_halted, n_halted;
    logic   r_error, n_error;

    logic    r_res_valid;
    logic    r_byte_valid, n_byte_valid;
    t_byte   r_data_byte, n_data_byte;
    logic    r_done, n_done;
    logic    r_bad, n_bad;
    t_length r_length, n_length;

    logic                char_acc;
    logic [5:0]          sym;
    logic [CMP_BITS-1:0] cap_ext;
    logic [CMP_BITS-1:0] cnt_max_ext;
    logic [CMP_BITS-1:0] cap_eff;
    logic [CMP_BITS-1:0] cnt_ext;
    logic [CMP_BITS-1:0] len_ext;

    assign o_cfg_ready  = 1'b1;
    assign o_char_stall = r_res_valid && i_res_stall;
    assign char_acc     = i_char_valid && !o_char_stall;

    assign sym         = i_char_in[5:0] - SYMBOL_OFFSET[5:0];
    assign cap_ext     = CMP_BITS'(r_capacity);
    assign cnt_max_ext = CMP_BITS'({COUNT_BITS{1'b1}});
    assign cap_eff     = (cap_ext < cnt_max_ext) ? cap_ext : cnt_max_ext;

    always_comb begin
        n_partial    = r_partial;
        n_phase      = r_phase;
        n_count      = r_count;
        n_halted     = r_halted;
        n_error      = r_error;
        n_byte_valid = 1'b0;
        n_data_byte  = '0;
        n_done       = 1'b0;
        cnt_ext      = '0;
        if (i_char_in == '0) begin
            n_done = 1'b1;
        end else if (!r_halted) begin
            if (i_char_in < SYMBOL_OFFSET) begin
                n_error  = 1'b1;
                n_halted = 1'b1;
                n_count  = '0;
            end else if (CMP_BITS'(r_count) >= cap_eff) begin
                n_halted = 1'b1;
            end else begin
                n_phase = t_phase'(r_phase + 2'd1);
                case (r_phase)
                    PH_FIRST: begin
                        n_partial = {sym, 2'b00};
                    end
                    PH_SECOND: begin
                        n_data_byte = r_partial | {6'b000000, sym[5:4]};
                        n_partial   = {sym[3:0], 4'b0000};
                    end
                    PH_THIRD: begin
                        n_data_byte = r_partial | {4'b0000, sym[5:2]};
                        n_partial   = {sym[1:0], 6'b000000};
                    end
                    PH_FOURTH: begin
                        n_data_byte = r_partial | {2'b00, sym};
                        n_partial   = '0;
                    end
                    default: begin
                        n_partial = '0;
                    end
                endcase
                if (r_phase != PH_FIRST) begin
                    n_byte_valid = 1'b1;
                    n_count      = r_count + COUNT_BITS'(1);
                end
            end
        end
        n_bad    = n_error;
        cnt_ext  = CMP_BITS'(n_count);
        len_ext  = n_error ? '0 : cnt_ext;
        n_length = len_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_phase   <= PH_FIRST;
            r_count   <= '0;
            r_halted  <= 1'b0;
            r_error   <= 1'b0;
        end else if (char_acc) begin
            if (n_done) begin
                r_partial <= '0;
                r_phase   <= PH_FIRST;
                r_count   <= '0;
                r_halted  <= 1'b0;
                r_error   <= 1'b0;
            end else begin
                r_partial <= n_partial;
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_halted  <= n_halted;
                r_error   <= n_error;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (char_acc) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (char_acc) begin
            r_byte_valid <= n_byte_valid;
            r_data_byte  <= n_data_byte;
            r_done       <= n_done;
            r_bad        <= n_bad;
            r_length     <= n_length;
        end
    end

    assign o_res_valid  = r_res_valid;
    assign o_byte_valid = r_byte_valid;
    assign o_data_byte  = r_data_byte;
    assign o_done_res   = r_done;
    assign o_bad_char   = r_bad;
    assign o_length     = r_length;

    // string end clears the decode state
    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        char_acc && (i_char_in == '0) |=> (r_count == '0) && (r_phase == PH_FIRST)
            && !r_halted && !r_error)
        else $error("decode state not cleared after end of string");

    // an error result always reports zero length
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_bad_char |-> (o_length == '0))
        else $error("nonzero length with bad character");

    // a halted string produces no bytes
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        char_acc && r_halted |=> !o_byte_valid)
        else $error("byte produced while halted");

    // end of string result never carries a byte
    a_done_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_done_res |-> !o_byte_valid && (o_data_byte == '0))
        else $error("byte on end of string result");

    // no byte is emitted at the first character of a group
    a_phase_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        char_acc && (r_phase == PH_FIRST) |=> !o_byte_valid)
        else $error("byte emitted on first character of a group");

endmodule

`default_nettype wire
